@@ hw/rtl/mdp_policy_value_solver_defines.svh @@
// Assertion macros shared by the policy value solver RTL.
`ifndef MDP_POLICY_VALUE_SOLVER_DEFINES_SVH
`define MDP_POLICY_VALUE_SOLVER_DEFINES_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define MDP_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define MDP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/mdp_pkg.sv @@
// Shared types and constants of the policy value solver.
`default_nettype none
package mdp_pkg;
    localparam int STATES  = 16;
    localparam int ACTIONS = 4;
    localparam int SW = 4;
    localparam int AW = 2;
    localparam logic [1:0] REQ_TRANS  = 2'd0;
    localparam logic [1:0] REQ_REWARD = 2'd1;
    localparam logic [1:0] REQ_POLICY = 2'd2;
    localparam logic [31:0] ONE_Q16 = 32'd65536;
    localparam logic [1:0] REG_DISCOUNT = 2'd0;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/mdp_div.sv @@
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturated.
`default_nettype none
module mdp_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    import mdp_pkg::*;
    logic [47:0] r_num;
    logic [31:0] r_den;
    logic [48:0] r_quo;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [32:0] n_rem;
    logic [32:0] n_sub;
    logic signed [65:0] n_res;

    always_comb begin
        n_rem = {r_rem, r_num[47]};
        n_sub = n_rem - {1'b0, r_den};
        n_res = r_neg ? -$signed({17'd0, r_quo}) : $signed({17'd0, r_quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_num  <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!n_sub[32]) begin
                    r_rem <= n_sub[31:0];
                    r_quo <= {r_quo[47:0], 1'b1};
                end else begin
                    r_rem <= n_rem[31:0];
                    r_quo <= {r_quo[47:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) r_busy <= 1'b0;
                if (r_cnt == 6'd1) o_done <= 1'b1;
            end
        end
    end

    always_comb o_quo = sat32(n_res);
endmodule
`default_nettype wire

@@ hw/rtl/mdp_policy_value_solver.sv @@
// Top level of the policy value solver: stores, system build, elimination and output.
// Load and policy items are taken one per cycle while the input is not stalled. A
// policy item with the last mark starts a solve that holds the input stalled until all
// values have been transferred: the build forms every entry of the system matrix in
// turn, and each elimination column takes a pivot scan, a row swap when the pivot row
// differs, a normalization of each entry in the divider, which works out 48 quotient
// bits, and the row updates through the work matrix memory, which has one read port
// and one write port. Values then leave one per cycle as the output is taken. No
// clearing pass follows reset.
`default_nettype none
`include "mdp_policy_value_solver_defines.svh"
module mdp_policy_value_solver (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [1:0]               i_action_id,
    input  wire logic [3:0]               i_from_state,
    input  wire logic [3:0]               i_to_state,
    input  wire logic signed [31:0]       i_data_value,
    input  wire logic                     i_last_item,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [3:0]                    o_state_index,
    output logic signed [31:0]            o_state_value,
    output logic                          o_singular,
    output logic                          o_last_result,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [1:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mdp_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_BRD, S_BWAIT, S_BMUL, S_BWR,
        S_CSTART, S_PRD, S_PCMP, S_SWRD, S_SWA, S_SWB, S_SWRHS,
        S_NRD, S_NWAIT, S_NDIV, S_NRHS, S_NRHSW,
        S_EF, S_EFW, S_EPRD, S_EPW, S_EMUL, S_EWR, S_ERHS, S_ERHSW, S_ENEXT,
        S_OUT, S_SING
    } t_state;

    t_state r_state;
    logic [16:0] r_discount;
    logic [AW-1:0] r_policy [STATES];

    logic signed [31:0] mem_trans [ACTIONS*STATES*STATES];
    logic signed [31:0] mem_rew [ACTIONS*STATES];
    logic signed [31:0] mem_work [STATES*STATES];
    logic signed [31:0] r_rhs [STATES];

    logic signed [31:0] r_trd, r_rrd, r_wrd;
    logic [9:0] r_taddr;
    logic [5:0] r_raddr;
    logic [7:0] r_waddr, r_wwaddr;
    logic signed [31:0] r_wwdata;
    logic r_wwe;

    logic [SW-1:0] r_i, r_j, r_col, r_row, r_piv;
    logic [SW:0] r_cnt;
    logic [32:0] r_best;
    logic signed [31:0] r_t, r_f, r_diag;
    logic signed [63:0] r_prod;
    logic r_div_start;
    logic div_done;
    logic signed [31:0] div_quo, r_div_num;

    logic in_acc, out_acc, cfg_wr;
    logic signed [31:0] wabs;
    logic signed [65:0] n_fl;

    assign in_acc = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_DISCOUNT) ? {15'd0, r_discount} : 32'd0;
    assign o_stall = (r_state != S_LOAD);

    mdp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_div_num), .i_den(r_diag), .o_done(div_done), .o_quo(div_quo)
    );

    // Floor of a signed product shifted by 16 is an arithmetic shift.
    always_comb n_fl = 66'(r_prod >>> 16);
    assign wabs = r_wrd;

    always_ff @(posedge i_clk) begin
        r_trd <= mem_trans[r_taddr];
        r_rrd <= mem_rew[r_raddr];
        r_wrd <= mem_work[r_waddr];
        if (r_wwe) mem_work[r_wwaddr] <= r_wwdata;
        if (in_acc && i_req_type == REQ_TRANS)
            mem_trans[{i_action_id, i_from_state, i_to_state}] <= i_data_value;
        if (in_acc && i_req_type == REQ_REWARD)
            mem_rew[{i_action_id, i_from_state}] <= i_data_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_discount <= 17'd64881;
            for (int k = 0; k < STATES; k++) r_policy[k] <= '0;
            o_valid <= 1'b0;
            r_wwe <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_wwe <= 1'b0;
            r_div_start <= 1'b0;
            if (cfg_wr && paddr == REG_DISCOUNT) r_discount <= pwdata[16:0];
            case (r_state)
                S_LOAD: begin
                    if (in_acc && i_req_type == REQ_POLICY) begin
                        r_policy[i_from_state] <= i_action_id;
                        if (i_last_item) begin
                            r_i <= '0; r_j <= '0;
                            r_state <= S_BRD;
                        end
                    end
                end
                S_BRD: begin
                    r_taddr <= {r_policy[r_i], r_i, r_j};
                    r_raddr <= {r_policy[r_i], r_i};
                    r_state <= S_BWAIT;
                end
                S_BWAIT: r_state <= S_BMUL;
                S_BMUL: begin
                    r_prod <= $signed({15'd0, r_discount}) * r_trd;
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_wwe <= 1'b1;
                    r_wwaddr <= {r_i, r_j};
                    r_wwdata <= sat32(((r_i == r_j) ? 66'sd65536 : 66'sd0) - n_fl);
                    if (r_j == SW'(STATES-1)) begin
                        r_rhs[r_i] <= r_rrd;
                        r_j <= '0;
                        if (r_i == SW'(STATES-1)) begin
                            r_col <= '0;
                            r_state <= S_CSTART;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                S_CSTART: begin
                    r_row <= r_col; r_piv <= r_col; r_best <= '0;
                    r_cnt <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_waddr <= {r_row, r_col};
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (r_waddr == {r_row, r_col} && r_cnt != 5'd1) begin
                        r_cnt <= 5'd1;
                    end else begin
                        r_cnt <= '0;
                        if ((wabs[31] ? 33'(-$signed({wabs[31], wabs})) : 33'(wabs))
                                > r_best) begin
                            r_best <= wabs[31] ? 33'(-$signed({wabs[31], wabs})) : 33'(wabs);
                            r_piv <= r_row;
                        end
                        if (r_row == SW'(STATES-1)) begin
                            r_state <= S_SWRD;
                            r_j <= '0;
                        end else begin
                            r_row <= r_row + 1'b1;
                            r_state <= S_PRD;
                        end
                    end
                end
                S_SWRD: begin
                    if (r_best == '0) r_state <= S_SING;
                    else if (r_piv == r_col) begin
                        r_j <= r_col; r_state <= S_NRD;
                    end else begin
                        r_waddr <= {r_piv, r_j};
                        r_cnt <= '0;
                        r_state <= S_SWA;
                    end
                end
                S_SWA: begin
                    if (r_cnt == '0) begin
                        r_cnt <= 5'd1;
                        r_waddr <= {r_col, r_j};
                    end else if (r_cnt == 5'd1) begin
                        r_t <= r_wrd; r_cnt <= 5'd2;
                    end else begin
                        r_wwe <= 1'b1; r_wwaddr <= {r_col, r_j}; r_wwdata <= r_t;
                        r_f <= r_wrd;
                        r_state <= S_SWB;
                    end
                end
                S_SWB: begin
                    r_wwe <= 1'b1; r_wwaddr <= {r_piv, r_j}; r_wwdata <= r_f;
                    if (r_j == SW'(STATES-1)) r_state <= S_SWRHS;
                    else begin
                        r_j <= r_j + 1'b1; r_state <= S_SWRD;
                    end
                end
                S_SWRHS: begin
                    r_rhs[r_piv] <= r_rhs[r_col];
                    r_rhs[r_col] <= r_rhs[r_piv];
                    r_j <= r_col;
                    r_state <= S_NRD;
                end
                S_NRD: begin
                    r_waddr <= {r_col, r_col};
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (r_waddr == {r_col, r_col} && r_cnt != 5'd3) r_cnt <= 5'd3;
                    else begin
                        r_diag <= r_wrd;
                        r_waddr <= {r_col, r_j};
                        r_state <= S_NDIV;
                        r_cnt <= 5'd4;
                    end
                end
                S_NDIV: begin
                    if (r_cnt == 5'd4) r_cnt <= 5'd5;
                    else if (r_cnt == 5'd5) begin
                        r_div_num <= r_wrd; r_div_start <= 1'b1; r_cnt <= 5'd6;
                    end else if (div_done) begin
                        r_wwe <= 1'b1; r_wwaddr <= {r_col, r_j}; r_wwdata <= div_quo;
                        if (r_j == SW'(STATES-1)) r_state <= S_NRHS;
                        else begin
                            r_j <= r_j + 1'b1;
                            r_waddr <= {r_col, r_j + 1'b1};
                            r_cnt <= 5'd4;
                        end
                    end
                end
                S_NRHS: begin
                    r_div_num <= r_rhs[r_col]; r_div_start <= 1'b1;
                    r_state <= S_NRHSW;
                end
                S_NRHSW: begin
                    if (div_done) begin
                        r_rhs[r_col] <= div_quo;
                        r_row <= '0;
                        r_state <= S_EF;
                    end
                end
                S_EF: begin
                    if (r_row == r_col) r_state <= S_ENEXT;
                    else begin
                        r_waddr <= {r_row, r_col};
                        r_cnt <= '0;
                        r_state <= S_EFW;
                    end
                end
                S_EFW: begin
                    if (r_cnt == '0) r_cnt <= 5'd1;
                    else begin
                        r_f <= r_wrd;
                        r_j <= r_col;
                        r_state <= (r_wrd == '0) ? S_ENEXT : S_EPRD;
                    end
                end
                S_EPRD: begin
                    r_waddr <= {r_col, r_j};
                    r_cnt <= '0;
                    r_state <= S_EPW;
                end
                S_EPW: begin
                    if (r_cnt == '0) r_cnt <= 5'd1;
                    else if (r_cnt == 5'd1) begin
                        r_prod <= r_f * r_wrd;
                        r_waddr <= {r_row, r_j};
                        r_cnt <= 5'd2;
                    end else if (r_cnt == 5'd2) r_cnt <= 5'd3;
                    else r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_wwe <= 1'b1; r_wwaddr <= {r_row, r_j};
                    r_wwdata <= sat32($signed({{34{r_wrd[31]}}, r_wrd}) - n_fl);
                    r_state <= S_EWR;
                end
                S_EWR: begin
                    if (r_j == SW'(STATES-1)) r_state <= S_ERHS;
                    else begin
                        r_j <= r_j + 1'b1; r_state <= S_EPRD;
                    end
                end
                S_ERHS: begin
                    r_prod <= r_f * r_rhs[r_col];
                    r_state <= S_ERHSW;
                end
                S_ERHSW: begin
                    r_rhs[r_row] <= sat32($signed({{34{r_rhs[r_row][31]}}, r_rhs[r_row]}) - n_fl);
                    r_state <= S_ENEXT;
                end
                S_ENEXT: begin
                    if (r_row == SW'(STATES-1)) begin
                        if (r_col == SW'(STATES-1)) begin
                            r_i <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_col <= r_col + 1'b1;
                            r_state <= S_CSTART;
                        end
                    end else begin
                        r_row <= r_row + 1'b1;
                        r_state <= S_EF;
                    end
                end
                S_OUT: begin
                    if (!o_valid || out_acc) begin
                        if (o_valid && o_last_result) begin
                            o_valid <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            o_valid <= 1'b1;
                            o_state_index <= r_i;
                            o_state_value <= r_rhs[r_i];
                            o_singular <= 1'b0;
                            o_last_result <= (r_i == SW'(STATES-1));
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_SING: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_state_index <= '0;
                        o_state_value <= '0;
                        o_singular <= 1'b1;
                        o_last_result <= 1'b1;
                    end else if (out_acc) begin
                        o_valid <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `MDP_ASSERT_IMPL(a_no_out_in_load, i_clk, i_rst_n, r_state == S_LOAD, !o_valid)
    `MDP_ASSERT_IMPL(a_sing_last, i_clk, i_rst_n, o_valid && o_singular, o_last_result)
    `MDP_ASSERT_NEXT(a_div_busy, i_clk, i_rst_n, r_div_start, !div_done)
endmodule
`default_nettype wire
